FILE: hdl/lnp_pkg.sv
`default_nettype none
package lnp_pkg;

  localparam int LNP_STACK_DEPTH = 128;
  localparam int NOTE_W = 7;
  localparam int KIND_W = 2;
  localparam int CNT_W = 8;

  localparam logic [KIND_W-1:0] K_NOTE_ON  = 2'd0;
  localparam logic [KIND_W-1:0] K_NOTE_OFF = 2'd1;
  localparam logic [KIND_W-1:0] K_CLEAR    = 2'd2;

  typedef struct packed {
    logic              legato;
    logic [NOTE_W-1:0] top_note;
    logic              top_valid;
    logic [CNT_W-1:0]  held_count;
    logic              multi_held;
    logic              was_down;
    logic              stack_full;
  } res_t;

  function automatic res_t make_res(input logic leg, input logic [NOTE_W-1:0] top,
                                    input logic [CNT_W-1:0] cnt, input logic down,
                                    input logic full);
    res_t r;
    r.legato     = leg;
    r.top_valid  = (cnt != '0);
    r.top_note   = (cnt != '0) ? top : '0;
    r.held_count = cnt;
    r.multi_held = (cnt > CNT_W'(1));
    r.was_down   = down;
    r.stack_full = full;
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: hdl/lnp_stack_ram.sv
`default_nettype none
module lnp_stack_ram
  import lnp_pkg::*;
#(
  parameter int STACK_DEPTH = LNP_STACK_DEPTH,
  parameter int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              re,
  input  wire logic [AW-1:0]     raddr,
  output logic      [NOTE_W-1:0] rd_data,
  input  wire logic              we,
  input  wire logic [AW-1:0]     waddr,
  input  wire logic [NOTE_W-1:0] wdata
);

  logic [NOTE_W-1:0] mem [STACK_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rd_data <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

FILE: hdl/lnp_seq.sv
`default_nettype none
module lnp_seq
  import lnp_pkg::*;
#(
  parameter int STACK_DEPTH = LNP_STACK_DEPTH,
  parameter int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1,
  parameter int CW = $clog2(STACK_DEPTH + 1)
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [KIND_W-1:0] kind,
  input  wire logic [NOTE_W-1:0] note,
  output logic                   re,
  output logic      [AW-1:0]     raddr,
  input  wire logic [NOTE_W-1:0] rd_data,
  output logic                   we,
  output logic      [AW-1:0]     waddr,
  output logic      [NOTE_W-1:0] wdata,
  output logic                   res_valid,
  input  wire logic              res_take,
  output res_t                   res
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_APPLY = 3'd2;
  localparam logic [2:0] S_TOPWT = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]        state;
  logic [KIND_W-1:0] kind_r;
  logic [NOTE_W-1:0] key_r;
  logic [NOTE_W-1:0] top_r;
  logic [CW-1:0]     total;
  logic [CW-1:0]     issue;
  logic [AW-1:0]     rd_idx;
  logic              rd_vld;
  logic              found;
  logic [AW-1:0]     pos;

  logic [CW-1:0] newt;
  logic [CW-1:0] top_idx;
  logic          scan_rd;
  logic          top_rd;
  logic          hit;
  logic          rd_last;
  logic          pos_last;
  logic          leg;
  logic          accept;

  assign accept    = in_valid && (state == S_IDLE);
  assign in_stall  = (state != S_IDLE);
  assign res_valid = (state == S_DONE);
  assign newt      = total - CW'(1);
  assign top_idx   = total - CW'(2);
  assign hit       = rd_vld && (state == S_SCAN) && !found && (rd_data == key_r);
  assign rd_last   = rd_vld && (CW'(rd_idx) == newt);
  assign pos_last  = (CW'(pos) == newt);
  assign leg       = !((total == '0) || ((total == CW'(1)) && found));

  always_comb begin
    scan_rd = (state == S_SCAN) && (issue < total);
    top_rd  = (state == S_APPLY) && (kind_r == K_NOTE_OFF) && found &&
              (newt != '0) && pos_last;
    re      = scan_rd || top_rd;
    raddr   = top_rd ? top_idx[AW-1:0] : issue[AW-1:0];
    we      = 1'b0;
    waddr   = rd_idx - AW'(1);
    wdata   = rd_data;
    if ((state == S_SCAN) && rd_vld && found && (kind_r == K_NOTE_OFF)) begin
      we = 1'b1;
    end else if ((state == S_APPLY) && (kind_r == K_NOTE_ON) && !found &&
                 (total < CW'(STACK_DEPTH))) begin
      we    = 1'b1;
      waddr = total[AW-1:0];
      wdata = key_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      total  <= '0;
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= scan_rd;
      rd_idx <= issue[AW-1:0];
      if (scan_rd) begin
        issue <= issue + CW'(1);
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            kind_r <= kind;
            key_r  <= note;
            issue  <= '0;
            found  <= 1'b0;
            if ((kind == K_NOTE_ON) || (kind == K_NOTE_OFF)) begin
              state <= (total == '0) ? S_APPLY : S_SCAN;
            end else if (kind == K_CLEAR) begin
              total <= '0;
              res   <= make_res(1'b0, top_r, '0, 1'b0, 1'b0);
              state <= S_DONE;
            end else begin
              res   <= make_res(1'b0, top_r, CNT_W'(total), 1'b0, 1'b0);
              state <= S_DONE;
            end
          end
        end
        S_SCAN: begin
          if (hit) begin
            found <= 1'b1;
            pos   <= rd_idx;
          end
          if (rd_last) begin
            state <= S_APPLY;
          end
        end
        S_APPLY: begin
          state <= S_DONE;
          if (kind_r == K_NOTE_ON) begin
            if (found) begin
              res <= make_res(leg, top_r, CNT_W'(total), 1'b1, 1'b0);
            end else if (total >= CW'(STACK_DEPTH)) begin
              res <= make_res(leg, top_r, CNT_W'(total), 1'b0, 1'b1);
            end else begin
              total <= total + CW'(1);
              top_r <= key_r;
              res   <= make_res(leg, key_r, CNT_W'(total + CW'(1)), 1'b0, 1'b0);
            end
          end else begin
            if (!found) begin
              res <= make_res(1'b0, top_r, CNT_W'(total), 1'b0, 1'b0);
            end else begin
              total <= newt;
              if (top_rd) begin
                state <= S_TOPWT;
              end else begin
                res <= make_res(1'b0, top_r, CNT_W'(newt), 1'b1, 1'b0);
              end
            end
          end
        end
        S_TOPWT: begin
          top_r <= rd_data;
          res   <= make_res(1'b0, rd_data, CNT_W'(total), 1'b1, 1'b0);
          state <= S_DONE;
        end
        S_DONE: begin
          if (res_take) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    total <= CW'(STACK_DEPTH))
    else $error("held count beyond stack depth");

  a_shift_off_only: assert property (@(posedge clk) disable iff (rst)
    (we && (state == S_SCAN)) |-> (kind_r == K_NOTE_OFF))
    else $error("stack shift outside a note-off");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    (accept && (kind == K_CLEAR)) |=> (total == '0))
    else $error("clear left keys held");

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    (rd_vld && (state == S_SCAN)) |-> (CW'(rd_idx) < total))
    else $error("scan read past top of stack");

endmodule
`default_nettype wire

FILE: hdl/last_note_priority_key_stack.sv
// Last-note-priority key tracker. Each transfer on the input carries a note-on, note-off or
// clear with a 7-bit note and yields exactly one result: legato flag, top held note, held
// count, multi-held, was-down and stack-full flags. Held notes live in a single stack memory
// (oldest at the bottom); whether a key is down is found by scanning that memory through its
// one read port, one entry per cycle, and a note-off closes the gap with writes made during
// the same pass. A note-on or note-off scans every held entry before it is applied and skips
// the scan when no key is held; one more read fetches the new top note when the top note is
// released while other keys stay held. A clear or an unused kind goes straight to the result.
// One item is in work at a time; the input is taken again as soon as the result sits in the
// output register, even while that result is stalled. Reset needs no clearing pass.
`default_nettype none
module last_note_priority_key_stack
  import lnp_pkg::*;
#(
  parameter int STACK_DEPTH = LNP_STACK_DEPTH
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [KIND_W-1:0] kind,
  input  wire logic [NOTE_W-1:0] note,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic                   legato,
  output logic      [NOTE_W-1:0] top_note,
  output logic                   top_valid,
  output logic      [CNT_W-1:0]  held_count,
  output logic                   multi_held,
  output logic                   was_down,
  output logic                   stack_full
);

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);

  logic              re;
  logic [AW-1:0]     raddr;
  logic [NOTE_W-1:0] rd_data;
  logic              we;
  logic [AW-1:0]     waddr;
  logic [NOTE_W-1:0] wdata;
  logic              res_valid;
  logic              res_take;
  res_t              res;
  res_t              out_r;

  lnp_stack_ram #(
    .STACK_DEPTH(STACK_DEPTH),
    .AW(AW)
  ) u_ram (
    .clk(clk),
    .re(re),
    .raddr(raddr),
    .rd_data(rd_data),
    .we(we),
    .waddr(waddr),
    .wdata(wdata)
  );

  lnp_seq #(
    .STACK_DEPTH(STACK_DEPTH),
    .AW(AW),
    .CW(CW)
  ) u_seq (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .kind(kind),
    .note(note),
    .re(re),
    .raddr(raddr),
    .rd_data(rd_data),
    .we(we),
    .waddr(waddr),
    .wdata(wdata),
    .res_valid(res_valid),
    .res_take(res_take),
    .res(res)
  );

  assign res_take = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_take) begin
      out_valid <= 1'b1;
      out_r     <= res;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  assign legato     = out_r.legato;
  assign top_note   = out_r.top_note;
  assign top_valid  = out_r.top_valid;
  assign held_count = out_r.held_count;
  assign multi_held = out_r.multi_held;
  assign was_down   = out_r.was_down;
  assign stack_full = out_r.stack_full;

  a_result_kept: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_take) |=> res_valid)
    else $error("pending result lost under stall");

endmodule
`default_nettype wire
